// File: rtl/afd_pkg.sv
// Shared types, constants and functions of the anisotropic diffusion frame unit.
package afd_pkg;

	localparam int ROM_DEPTH = 2048;
	localparam int ROM_AW    = 11;

	// Item kinds
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_RUN  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_PASS_COUNT   = 2'd0;
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

	// Steps of the per-pixel sequence
	localparam logic [2:0] STEP_CENTER = 3'd0;
	localparam logic [2:0] STEP_NORTH  = 3'd1;
	localparam logic [2:0] STEP_SOUTH  = 3'd2;
	localparam logic [2:0] STEP_EAST   = 3'd3;
	localparam logic [2:0] STEP_WEST   = 3'd4;
	localparam logic [2:0] STEP_FLUX_W = 3'd5;
	localparam logic [2:0] STEP_ACC_W  = 3'd6;
	localparam logic [2:0] STEP_LAST   = 3'd7;

	typedef struct packed {
		logic [3:0] pass_count;
		logic [6:0] frame_width;
		logic [6:0] frame_height;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_DRAIN,
		ST_PIXEL,
		ST_DONE
	} state_t;

	typedef logic [15:0] flux_rom_t [ROM_DEPTH];

	// Build the flux table: i/16 * exp(-(i/16)^2/900) in Q8.8, exp by Q31 recurrence
	function automatic flux_rom_t build_flux_rom();
		flux_rom_t rom;
		logic [63:0] a;
		logic [63:0] b;
		a = 64'd1 << 31;
		b = 64'd2147474327;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			rom[i] = 16'(((64'(i) * a) + (64'd1 << 26)) >> 27);
			a = (a * b + (64'd1 << 30)) >> 31;
			b = (b * 64'd2147465007 + (64'd1 << 30)) >> 31;
		end
		return rom;
	endfunction

	// Round Q8.8 half to even and saturate to a byte
	function automatic logic [7:0] to_byte(input logic [15:0] v);
		logic [8:0] ip;
		ip = {1'b0, v[15:8]};
		if (v[7:0] > 8'd128 || (v[7:0] == 8'd128 && ip[0])) begin
			ip = ip + 9'd1;
		end
		return ip[8] ? 8'hff : ip[7:0];
	endfunction

endpackage

// File: rtl/afd_in_if.sv
// Input channel: command beats with valid/ready handshake.
interface afd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  pixel_in;
	logic [11:0] pixel_index;

	modport source(output valid, kind, pixel_in, pixel_index, input ready);
	modport sink(input valid, kind, pixel_in, pixel_index, output ready);
endinterface

// File: rtl/afd_out_if.sv
// Output channel: result beats with valid/ready handshake.
interface afd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_out;
	logic       run_done;

	modport source(output valid, pixel_out, run_done, input ready);
	modport sink(input valid, pixel_out, run_done, output ready);
endinterface

// File: rtl/afd_flux_rom.sv
// Flux lookup table with a registered read port.
module afd_flux_rom (
	input  logic                     clk,
	input  logic [afd_pkg::ROM_AW-1:0] addr,
	output logic [15:0]              data
);
	import afd_pkg::*;

	localparam flux_rom_t ROM = build_flux_rom();

	// Registered lookup
	always_ff @(posedge clk) begin
		data <= ROM[addr];
	end
endmodule

// File: rtl/afd_mem.sv
// Simple dual-port pixel memory: one write port, one registered read port.
module afd_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);
	logic [15:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/afd_regs.sv
// APB-style configuration registers.
module afd_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output afd_pkg::cfg_t       cfg
);
	import afd_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Take register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pass_count   <= 4'd1;
			cfg_q.frame_width  <= 7'd64;
			cfg_q.frame_height <= 7'd64;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_PASS_COUNT:   cfg_q.pass_count   <= pwdata[3:0];
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[6:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[3:2])
			REG_PASS_COUNT:   prdata = {28'd0, cfg_q.pass_count};
			REG_FRAME_WIDTH:  prdata = {25'd0, cfg_q.frame_width};
			REG_FRAME_HEIGHT: prdata = {25'd0, cfg_q.frame_height};
			default:          prdata = 32'd0;
		endcase
	end
endmodule

// File: rtl/anisotropic_diffusion_frame_unit.sv
// Top level of the anisotropic diffusion frame unit.
// Perona-Malik diffusion over a frame of up to MAX_WIDTH x MAX_HEIGHT pixels held as Q8.8
// in a frame memory, with a second memory holding the previous pass. A load beat gives no
// result; a read beat is answered from the registered frame memory read through ST_READ.
// A run beat is answered through ST_DONE once all passes end: each pass copies the frame
// into the pass memory, one pixel a cycle, then updates every interior pixel in the steps
// STEP_CENTER to STEP_LAST, set by the single read port of the pass memory (five reads per
// pixel) and the flux table lookups that follow it. Both memories hold undefined data until loaded.
module anisotropic_diffusion_frame_unit #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	afd_in_if.sink      in_ch,
	afd_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import afd_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int NW    = $clog2(DEPTH + 1);

	cfg_t cfg;

	state_t state_q, state_d;
	logic [2:0]    step_q;
	logic [3:0]    pass_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] n_last_q;
	logic [AW-1:0] p_q;
	logic [WW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic [15:0]   ctr_q;
	logic signed [15:0] acc_q;
	logic          neg_s1, zero_s1, flux_v_s1;
	logic          cp_we_s1;
	logic [AW-1:0] cp_addr_s1;
	logic          rd_oob_q;
	logic          out_v_q, out_done_q;
	logic [7:0]    out_pix_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [NW-1:0] n_pix;
	logic          in_fire, out_fire, idx_ok, small_frame;
	logic          col_end, row_end, pass_end;
	logic [AW-1:0] in_addr, w_ext;

	logic          frame_we;
	logic [AW-1:0] frame_waddr, frame_raddr, pass_raddr;
	logic [15:0]   frame_wdata, frame_rdata, pass_rdata, rom_data;

	logic signed [16:0] diff;
	logic [16:0]   mag;
	logic [11:0]   rom_idx;
	logic signed [15:0] flux;
	logic signed [19:0] t_sum;
	logic [17:0]   nv;
	logic [15:0]   new_pix;

	afd_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	afd_mem #(.DEPTH(DEPTH), .AW(AW)) u_frame_mem (
		.clk(clk), .we(frame_we), .waddr(frame_waddr), .wdata(frame_wdata),
		.raddr(frame_raddr), .rdata(frame_rdata)
	);

	afd_mem #(.DEPTH(DEPTH), .AW(AW)) u_pass_mem (
		.clk(clk), .we(cp_we_s1), .waddr(cp_addr_s1), .wdata(frame_rdata),
		.raddr(pass_raddr), .rdata(pass_rdata)
	);

	afd_flux_rom u_rom (
		.clk(clk), .addr(rom_idx[ROM_AW-1:0]), .data(rom_data)
	);

	// Clamp the frame size to the store; a zero width or height counts as one
	always_comb begin
		if (cfg.frame_width == 7'd0) begin
			w_eff = WW'(1);
		end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg.frame_width);
		end
		if (cfg.frame_height == 7'd0) begin
			h_eff = HW'(1);
		end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg.frame_height);
		end
	end

	assign n_pix       = NW'(w_eff) * NW'(h_eff);
	assign small_frame = (w_eff < WW'(3)) || (h_eff < HW'(3));
	assign w_ext       = AW'(w_eff);
	assign in_addr     = AW'(in_ch.pixel_index);
	assign idx_ok      = 32'(in_ch.pixel_index) < 32'(DEPTH);

	// Handshakes
	assign in_ch.ready   = (state_q == ST_IDLE) && (!out_v_q || out_ch.ready);
	assign in_fire       = in_ch.valid & in_ch.ready;
	assign out_ch.valid  = out_v_q;
	assign out_ch.pixel_out = out_pix_q;
	assign out_ch.run_done  = out_done_q;
	assign out_fire      = out_v_q & out_ch.ready;

	assign col_end  = col_q == (w_eff - WW'(2));
	assign row_end  = row_q == (h_eff - HW'(2));
	assign pass_end = (step_q == STEP_LAST) && col_end && row_end;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_ch.kind == KIND_READ) begin
					state_d = ST_READ;
				end else if (in_fire && in_ch.kind == KIND_RUN) begin
					state_d = (cfg.pass_count == 4'd0 || small_frame) ? ST_DONE : ST_COPY;
				end
			end
			ST_READ:  state_d = ST_IDLE;
			ST_COPY: begin
				if (cnt_q == n_last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_PIXEL;
			ST_PIXEL: begin
				if (pass_end) begin
					state_d = (pass_q == cfg.pass_count - 4'd1) ? ST_DONE : ST_COPY;
				end
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Memory addresses and write strobes
	always_comb begin
		frame_raddr = (state_q == ST_COPY) ? cnt_q : in_addr;
		frame_we    = 1'b0;
		frame_waddr = in_addr;
		frame_wdata = {in_ch.pixel_in, 8'd0};
		if (state_q == ST_IDLE && in_fire && in_ch.kind == KIND_LOAD && idx_ok) begin
			frame_we = 1'b1;
		end else if (state_q == ST_PIXEL && step_q == STEP_LAST) begin
			frame_we    = 1'b1;
			frame_waddr = p_q;
			frame_wdata = new_pix;
		end
		case (step_q)
			STEP_CENTER: pass_raddr = p_q;
			STEP_NORTH:  pass_raddr = p_q - w_ext;
			STEP_SOUTH:  pass_raddr = p_q + w_ext;
			STEP_EAST:   pass_raddr = p_q + AW'(1);
			default:     pass_raddr = p_q - AW'(1);
		endcase
	end

	// Neighbor difference to table index; flux with sign; new pixel value
	always_comb begin
		diff    = $signed({1'b0, pass_rdata}) - $signed({1'b0, ctr_q});
		mag     = diff[16] ? 17'(-diff) : 17'(diff);
		rom_idx = mag[15:4];
		if (zero_s1) begin
			flux = 16'sd0;
		end else begin
			flux = neg_s1 ? -$signed(rom_data) : $signed(rom_data);
		end
		t_sum = $signed({2'b00, ctr_q, 2'b00}) + 20'(acc_q) + 20'sd2;
		nv    = t_sum[19] ? 18'd0 : t_sum[19:2];
		new_pix = (nv > 18'd65535) ? 16'hffff : nv[15:0];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= STEP_CENTER;
			pass_q    <= 4'd0;
			cnt_q     <= '0;
			cp_we_s1  <= 1'b0;
			flux_v_s1 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			cp_we_s1 <= (state_q == ST_COPY);
			flux_v_s1 <= (state_q == ST_PIXEL) &&
				(step_q == STEP_SOUTH || step_q == STEP_EAST ||
				 step_q == STEP_WEST || step_q == STEP_FLUX_W);
			// advance the copy sweep and the pixel sequence
			if (state_d == ST_COPY && state_q != ST_COPY) begin
				cnt_q <= '0;
			end else if (state_q == ST_COPY) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (state_q == ST_DRAIN) begin
				step_q <= STEP_CENTER;
			end else if (state_q == ST_PIXEL) begin
				step_q <= step_q + 3'd1;
			end
			if (state_q == ST_IDLE) begin
				pass_q <= 4'd0;
			end else if (state_q == ST_PIXEL && pass_end) begin
				pass_q <= pass_q + 4'd1;
			end
			// hold a result until it is taken
			if (state_q == ST_READ || state_q == ST_DONE) begin
				out_v_q <= 1'b1;
			end else if (out_fire) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		cp_addr_s1 <= cnt_q;
		neg_s1     <= diff[16];
		zero_s1    <= rom_idx[11];
		if (in_fire) begin
			rd_oob_q <= !idx_ok;
			n_last_q <= AW'(n_pix - NW'(1));
		end
		if (state_d == ST_COPY && state_q != ST_COPY) begin
			p_q   <= w_ext + AW'(1);
			col_q <= WW'(1);
			row_q <= HW'(1);
		end else if (state_q == ST_PIXEL && step_q == STEP_LAST) begin
			if (col_end) begin
				p_q   <= p_q + AW'(3);
				col_q <= WW'(1);
				row_q <= row_q + HW'(1);
			end else begin
				p_q   <= p_q + AW'(1);
				col_q <= col_q + WW'(1);
			end
		end
		if (state_q == ST_PIXEL && step_q == STEP_NORTH) begin
			ctr_q <= pass_rdata;
			acc_q <= 16'sd0;
		end else if (flux_v_s1) begin
			acc_q <= acc_q + flux;
		end
		if (state_q == ST_READ) begin
			out_pix_q  <= rd_oob_q ? 8'd0 : to_byte(frame_rdata);
			out_done_q <= 1'b0;
		end else if (state_q == ST_DONE) begin
			out_pix_q  <= 8'd0;
			out_done_q <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	// Input is only taken while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == ST_IDLE)
		else $error("input taken while busy");

	// A pixel update never lands on the top row or left column
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PIXEL && step_q == STEP_LAST) |-> (col_q != '0 && row_q != '0))
		else $error("border pixel updated");

	// A new result comes only from a read or the end of a run
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_DONE))
		else $error("spurious result");
`endif
endmodule
